// File: src/des_ks_pkg.sv
// Package: DES key schedule permutation tables, types and helper functions.
`default_nettype none
package des_ks_pkg;

   localparam int HalfBits   = 28;
   localparam int KeyBits    = 64;
   localparam int CdBits     = 56;
   localparam int SubkeyBits = 48;
   localparam int NumRounds  = 16;

   typedef logic [7:0] tbl_entry_type;

   localparam tbl_entry_type Pc1Table [CdBits] = '{
      8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
      8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
      8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
      8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39,
      8'd31, 8'd23, 8'd15, 8'd7,  8'd62, 8'd54, 8'd46, 8'd38,
      8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
      8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
   };

   localparam tbl_entry_type Pc2Table [SubkeyBits] = '{
      8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28,
      8'd15, 8'd6,  8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,
      8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
      8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40,
      8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
      8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
   };

   // The two key halves C and D, C in the upper position.
   typedef struct packed {
      logic [HalfBits-1:0] c;
      logic [HalfBits-1:0] d;
   } halves_type;

   typedef logic [3:0] round_idx_type;

   // PC-1: output bit k (MSB first) is key bit Pc1Table[k-1] (MSB = bit 1).
   function automatic halves_type pc1(input logic [KeyBits-1:0] key);
      logic [CdBits-1:0] cd;
      cd = '0;
      for (int i = 0; i < CdBits; i++) begin
         cd[CdBits-1-i] = key[KeyBits - int'(Pc1Table[i])];
      end
      return halves_type'(cd);
   endfunction

   // PC-2: output bit j (MSB first) is C:D bit Pc2Table[j-1] (MSB = bit 1).
   function automatic logic [SubkeyBits-1:0] pc2(input halves_type cd);
      logic [CdBits-1:0]     flat;
      logic [SubkeyBits-1:0] sub;
      flat = cd;
      sub  = '0;
      for (int i = 0; i < SubkeyBits; i++) begin
         sub[SubkeyBits-1-i] = flat[CdBits - int'(Pc2Table[i])];
      end
      return sub;
   endfunction

   // Rounds 1, 2, 9 and 16 rotate by one bit; all others by two.
   function automatic logic single_shift(input round_idx_type idx);
      return (idx == 4'd0) || (idx == 4'd1) || (idx == 4'd8) || (idx == 4'd15);
   endfunction

endpackage
`default_nettype wire

// File: src/des_key_schedule.sv
// Top level: DES key schedule, one 64-bit key in, sixteen round subkeys out.
//
// Usage:
//  - Request channel (req_*): one 64-bit DES key per request, key bit 1 in
//    the MSB. Parity bits are ignored. Accepted when req_valid && !req_stall.
//  - Result channel (rsp_*): sixteen results per key, in round order, each
//    with the 48-bit subkey, its round number (1..16) and rsp_last_subkey
//    set on round 16. Taken when rsp_valid && !rsp_stall.
//  - Order: an accepted key is loaded into the halves register; round 1
//    then reaches rsp_* through the result register. The single round unit
//    produces one subkey per cycle into the result register, so the later
//    rounds follow one per cycle while the receiver takes them.
//  - req_stall is high while rounds of the current key are still to be
//    produced; it drops in the cycle that moves round 16 into the result
//    register, so the next key is accepted at that same edge and keys
//    follow with no gap. While round 16 waits, rsp_stall may keep it high.
//  - When the receiver stalls, the result register holds its payload and
//    the round unit pauses; nothing is dropped or repeated.
//  - Reset (synchronous, active high) drops any key in progress and any
//    pending result.
`default_nettype none
module des_key_schedule (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [63:0] req_cipher_key,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [47:0] rsp_subkey,
   output logic [4:0]  rsp_round_number,
   output logic        rsp_last_subkey
);

   // Round engine state: key halves, next round index, busy flag.
   des_ks_pkg::halves_type    halves_ff, halves_in;
   des_ks_pkg::round_idx_type round_ff, round_in;
   logic                      busy_ff, busy_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [47:0]               subkey_ff, subkey_in;
   logic [4:0]                round_num_ff, round_num_in;
   logic                      last_ff, last_in;

   des_ks_pkg::halves_type    halves_next;
   logic [47:0]               round_subkey;
   logic                      req_accept;
   logic                      out_load;
   logic                      round_last;

   des_ks_round u_round (
      .halves_cur  (halves_ff),
      .round_idx   (round_ff),
      .halves_next (halves_next),
      .subkey      (round_subkey)
   );

   // Advance a round whenever the result register is free or being emptied.
   assign out_load   = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign round_last = (round_ff == 4'(des_ks_pkg::NumRounds - 1));

   // Stall requests while rounds remain; release as round 16 moves out.
   assign req_stall  = busy_ff && !(out_load && round_last);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      halves_in    = halves_ff;
      round_in     = round_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      subkey_in    = subkey_ff;
      round_num_in = round_num_ff;
      last_in      = last_ff;

      if (req_accept) begin
         // Load PC-1 of the new key and restart at round 1.
         halves_in = des_ks_pkg::pc1(req_cipher_key);
         round_in  = '0;
         busy_in   = 1'b1;
      end else if (out_load) begin
         halves_in = halves_next;
         round_in  = round_ff + 4'd1;
         busy_in   = !round_last;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         subkey_in    = round_subkey;
         round_num_in = {1'b0, round_ff} + 5'd1;
         last_in      = round_last;
      end else if (!rsp_stall) begin
         // Drop the result once taken.
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      halves_ff    <= halves_in;
      subkey_ff    <= subkey_in;
      round_num_ff <= round_num_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_subkey       = subkey_ff;
   assign rsp_round_number = round_num_ff;
   assign rsp_last_subkey  = last_ff;

endmodule
`default_nettype wire

// File: src/des_ks_round.sv
// One key schedule round: rotate both halves and apply PC-2.
`default_nettype none
module des_ks_round (
   input  wire des_ks_pkg::halves_type      halves_cur,
   input  wire des_ks_pkg::round_idx_type   round_idx,
   output des_ks_pkg::halves_type           halves_next,
   output logic [des_ks_pkg::SubkeyBits-1:0] subkey
);

   always_comb begin
      if (des_ks_pkg::single_shift(round_idx)) begin
         halves_next.c = {halves_cur.c[des_ks_pkg::HalfBits-2:0],
                          halves_cur.c[des_ks_pkg::HalfBits-1]};
         halves_next.d = {halves_cur.d[des_ks_pkg::HalfBits-2:0],
                          halves_cur.d[des_ks_pkg::HalfBits-1]};
      end else begin
         halves_next.c = {halves_cur.c[des_ks_pkg::HalfBits-3:0],
                          halves_cur.c[des_ks_pkg::HalfBits-1 -: 2]};
         halves_next.d = {halves_cur.d[des_ks_pkg::HalfBits-3:0],
                          halves_cur.d[des_ks_pkg::HalfBits-1 -: 2]};
      end
      subkey = des_ks_pkg::pc2(halves_next);
   end

endmodule
`default_nettype wire
